FILE: hw/rtl/ebsc_pkg.sv
// types and byte constants shared by the escape byte stuffing codec
package ebsc_pkg;

    // escape marker and the code that follows it for each special byte
    localparam logic [7:0] ESC_BYTE = 8'hEF;
    localparam logic [7:0] CODE_1A  = 8'hEA;
    localparam logic [7:0] CODE_EF  = 8'hEF;
    localparam logic [7:0] CODE_1B  = 8'hEB;
    localparam logic [7:0] CODE_03  = 8'hE3;

    // raw bytes that need stuffing
    localparam logic [7:0] RAW_1A = 8'h1A;
    localparam logic [7:0] RAW_EF = 8'hEF;
    localparam logic [7:0] RAW_1B = 8'h1B;
    localparam logic [7:0] RAW_03 = 8'h03;

    // direction register values
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // input transaction payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_last;
    } t_in_item;

    // output transaction payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       frame_end;
    } t_out_item;

endpackage

FILE: hw/rtl/escape_byte_stuffing_codec.sv
// escape byte stuffing codec: input register, single-pass coding, two-slot output
//
// Byte-stuffing codec for a serial link. With direction = 0 it stuffs bytes:
// 0x1A, 0xEF, 0x1B and 0x03 go out as 0xEF followed by 0xEA, 0xEF, 0xEB or 0xE3.
// With direction = 1 it unstuffs: a 0xEF that does not end a frame is held
// until the next byte shows whether it starts a code pair or stands as a literal.
// Channels: input transactions on i_in_valid / o_in_stall / i_in_data, output
// transactions on o_out_valid / i_out_stall / o_out_data. Each input byte gives
// zero, one or two output bytes; run_end marks the last one and frame_end the
// last one of a frame. The direction register is written through i_cfg_we /
// i_cfg_wdata; the user must do so only while the block is idle, as the block
// does not enforce it; a write drops any held escape. Throughput, while the
// receiver does not stall: one output byte per cycle, set by the single output
// register, so one input per cycle for plain bytes; after a stuffed byte the
// next waits until the second byte leaves its slot. The input register takes
// a new byte while a result waits at the output. Reset (synchronous, active
// low) empties both stages, selects encode and clears the held escape. When
// the receiver stalls, the output holds, the second byte of a pair waits in its
// slot and the input stalls once its register is full.
module escape_byte_stuffing_codec (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ebsc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ebsc_pkg::t_out_item o_out_data
);

    // registers
    logic                r_direction;
    logic                r_esc_pending;
    logic                r_in_valid;
    ebsc_pkg::t_in_item  r_in;
    logic                r_out_valid;
    ebsc_pkg::t_out_item r_out;
    logic                r_sec_valid;
    ebsc_pkg::t_out_item r_sec;

    // handshake and stage movement
    logic in_accept;
    logic out_take;
    logic out_free;
    logic consume;

    // results of the coding pass
    logic [1:0]          n_count;
    logic [7:0]          n_byte0;
    logic [7:0]          n_byte1;
    logic                n_esc_pending;
    logic [7:0]          dec_raw;
    logic                dec_hit;
    logic [7:0]          enc_code;
    logic                enc_hit;
    logic                plain;
    ebsc_pkg::t_out_item n_item0;
    ebsc_pkg::t_out_item n_item1;

    assign out_take   = r_out_valid && !i_out_stall;
    assign out_free   = !r_out_valid || out_take;
    assign consume    = r_in_valid && !r_sec_valid && out_free;
    assign o_in_stall = r_in_valid && !consume;
    assign in_accept  = i_in_valid && !o_in_stall;

    // code lookups for stuffing and unstuffing
    always_comb begin
        enc_hit  = 1'b1;
        enc_code = ebsc_pkg::CODE_1A;
        case (r_in.data_byte)
            ebsc_pkg::RAW_1A: enc_code = ebsc_pkg::CODE_1A;
            ebsc_pkg::RAW_EF: enc_code = ebsc_pkg::CODE_EF;
            ebsc_pkg::RAW_1B: enc_code = ebsc_pkg::CODE_1B;
            ebsc_pkg::RAW_03: enc_code = ebsc_pkg::CODE_03;
            default:          enc_hit  = 1'b0;
        endcase
        dec_hit = 1'b1;
        dec_raw = ebsc_pkg::RAW_1A;
        case (r_in.data_byte)
            ebsc_pkg::CODE_1A: dec_raw = ebsc_pkg::RAW_1A;
            ebsc_pkg::CODE_EF: dec_raw = ebsc_pkg::RAW_EF;
            ebsc_pkg::CODE_1B: dec_raw = ebsc_pkg::RAW_1B;
            ebsc_pkg::CODE_03: dec_raw = ebsc_pkg::RAW_03;
            default:           dec_hit = 1'b0;
        endcase
    end

    // single coding pass over the registered input byte
    always_comb begin
        n_count       = 2'd0;
        n_byte0       = r_in.data_byte;
        n_byte1       = r_in.data_byte;
        n_esc_pending = 1'b0;
        plain         = 1'b1;
        if (r_direction == ebsc_pkg::DIR_ENCODE) begin
            if (enc_hit) begin
                n_count = 2'd2;
                n_byte0 = ebsc_pkg::ESC_BYTE;
                n_byte1 = enc_code;
            end else begin
                n_count = 2'd1;
            end
        end else begin
            // resolve a held escape first
            if (r_esc_pending) begin
                n_count = 2'd1;
                if (dec_hit) begin
                    n_byte0 = dec_raw;
                    plain   = 1'b0;
                end else begin
                    n_byte0 = ebsc_pkg::ESC_BYTE;
                end
            end
            if (plain) begin
                if (r_in.data_byte == ebsc_pkg::ESC_BYTE && !r_in.frame_last) begin
                    n_esc_pending = 1'b1;
                end else begin
                    n_count = n_count + 2'd1;
                end
            end
        end
        n_item0.out_byte  = n_byte0;
        n_item0.run_end   = (n_count == 2'd1);
        n_item0.frame_end = (n_count == 2'd1) && r_in.frame_last;
        n_item1.out_byte  = n_byte1;
        n_item1.run_end   = 1'b1;
        n_item1.frame_end = r_in.frame_last;
    end

    // configuration, input register and output slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction   <= ebsc_pkg::DIR_ENCODE;
            r_esc_pending <= 1'b0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_sec_valid   <= 1'b0;
        end else begin
            // input register
            if (in_accept) begin
                r_in_valid <= 1'b1;
                r_in       <= i_in_data;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            // escape state and direction
            if (i_cfg_we) begin
                r_direction   <= i_cfg_wdata;
                r_esc_pending <= 1'b0;
            end else if (consume) begin
                r_esc_pending <= n_esc_pending;
            end
            // output slots
            if (r_sec_valid) begin
                if (out_take) begin
                    r_out       <= r_sec;
                    r_sec_valid <= 1'b0;
                end
            end else if (consume) begin
                r_out_valid <= (n_count != 2'd0);
                r_out       <= n_item0;
                r_sec_valid <= (n_count == 2'd2);
                r_sec       <= n_item1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // second byte of a pair only waits behind a first byte
    a_sec_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec_valid |-> r_out_valid)
        else $error("second slot filled with empty output register");

    // no new byte is coded while a second byte is waiting
    a_no_consume_with_sec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec_valid |-> !consume)
        else $error("input consumed over a waiting second byte");

    // frame end only on the last byte of a run
    a_frame_end_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.frame_end |-> r_out.run_end)
        else $error("frame_end without run_end");

    // nothing is held after the last byte of a frame
    a_pending_clear_at_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && r_in.frame_last |=> !r_esc_pending)
        else $error("escape still held after frame end");

    // encoding never holds an escape
    a_encode_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && r_direction == ebsc_pkg::DIR_ENCODE && !i_cfg_we |=> !r_esc_pending)
        else $error("escape held in encode mode");

endmodule

FILE: tb/sv/escape_byte_stuffing_codec_test.sv
// self-checking testbench for the escape byte stuffing codec
`timescale 1ns / 100ps

module escape_byte_stuffing_codec_test;

    localparam int RANDOM_ITEMS = 1100;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int USE_MODEL    = -1;
    localparam int DRAIN_CYCLES = 4;

    typedef enum logic {ROW_BYTE, ROW_DIR} t_row_kind;

    // one line of the directed stimulus table
    typedef struct {
        t_row_kind           kind;
        logic [7:0]          data;
        logic                last;
        int                  n_typed;
        ebsc_pkg::t_out_item r0;
        ebsc_pkg::t_out_item r1;
    } t_stim_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic                i_cfg_wdata = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    ebsc_pkg::t_in_item  i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    ebsc_pkg::t_out_item o_out_data;

    // codec state as seen by the checker
    logic      model_dir      = ebsc_pkg::DIR_ENCODE;
    logic      model_esc_held = 1'b0;

    ebsc_pkg::t_out_item expected_bytes[$];
    t_stim_row           directed_rows[$];
    int                  mismatch_count = 0;
    int                  cycle_count    = 0;
    bit                  send_calm      = 1'b0;
    bit                  recv_calm      = 1'b0;
    int                  recv_wait      = 0;
    logic                recv_stall_nxt;
    ebsc_pkg::t_out_item want;

    escape_byte_stuffing_codec dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // idle cycles between transactions, with calm stretches of none
    function automatic int draw_wait(input bit calm);
        if (calm) return 0;
        if ($urandom_range(0, 2) == 0) return $urandom_range(0, 18);
        return $urandom_range(0, 2);
    endfunction

    // byte mix weighted toward escape, raw specials and codes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 15))
            0, 1, 2: return ebsc_pkg::ESC_BYTE;
            3:       return ebsc_pkg::RAW_1A;
            4:       return ebsc_pkg::RAW_1B;
            5:       return ebsc_pkg::RAW_03;
            6:       return ebsc_pkg::CODE_1A;
            7:       return ebsc_pkg::CODE_1B;
            8:       return ebsc_pkg::CODE_03;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic ebsc_pkg::t_out_item out_of(input logic [7:0] b, input logic re,
                                                   input logic fe);
        return {b, re, fe};
    endfunction

    function automatic void add_row(input t_row_kind kind, input logic [7:0] data,
                                    input logic last, input int n,
                                    input ebsc_pkg::t_out_item r0,
                                    input ebsc_pkg::t_out_item r1);
        t_stim_row r;
        r.kind    = kind;
        r.data    = data;
        r.last    = last;
        r.n_typed = n;
        r.r0      = r0;
        r.r1      = r1;
        directed_rows.push_back(r);
    endfunction

    // stuff or unstuff one byte, update held escape, queue the output bytes if queue_it is set
    function automatic void stuff_or_unstuff(input logic [7:0] b, input logic last,
                                             input bit queue_it);
        logic [7:0] bytes_out [0:1];
        int         n;
        logic       plain;
        n     = 0;
        plain = 1'b1;
        if (model_dir == ebsc_pkg::DIR_ENCODE) begin
            bytes_out[0] = ebsc_pkg::ESC_BYTE;
            n            = 2;
            case (b)
                ebsc_pkg::RAW_1A: bytes_out[1] = ebsc_pkg::CODE_1A;
                ebsc_pkg::RAW_EF: bytes_out[1] = ebsc_pkg::CODE_EF;
                ebsc_pkg::RAW_1B: bytes_out[1] = ebsc_pkg::CODE_1B;
                ebsc_pkg::RAW_03: bytes_out[1] = ebsc_pkg::CODE_03;
                default: begin
                    bytes_out[0] = b;
                    n            = 1;
                end
            endcase
            model_esc_held = 1'b0;
        end else begin
            // held escape: either a code pair or a literal escape byte
            if (model_esc_held) begin
                model_esc_held = 1'b0;
                plain          = 1'b0;
                n              = 1;
                case (b)
                    ebsc_pkg::CODE_1A: bytes_out[0] = ebsc_pkg::RAW_1A;
                    ebsc_pkg::CODE_EF: bytes_out[0] = ebsc_pkg::RAW_EF;
                    ebsc_pkg::CODE_1B: bytes_out[0] = ebsc_pkg::RAW_1B;
                    ebsc_pkg::CODE_03: bytes_out[0] = ebsc_pkg::RAW_03;
                    default: begin
                        bytes_out[0] = ebsc_pkg::ESC_BYTE;
                        plain        = 1'b1;
                    end
                endcase
            end
            if (plain) begin
                if (b == ebsc_pkg::ESC_BYTE && !last) begin
                    model_esc_held = 1'b1;
                end else begin
                    bytes_out[n] = b;
                    n++;
                end
            end
            if (last) model_esc_held = 1'b0;
        end
        if (queue_it) begin
            for (int k = 0; k < n; k++)
                expected_bytes.push_back(out_of(bytes_out[k], k == n - 1,
                                                (k == n - 1) && last));
        end
    endfunction

    // one input transaction after a random gap; holds payload until taken
    task automatic send_byte(input logic [7:0] b, input logic last, input bit use_model);
        int gap;
        if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= {b, last};
        do @(posedge i_clk); while (o_in_stall);
        stuff_or_unstuff(b, last, use_model);
    endtask

    // direction write once the codec has gone quiet
    task automatic write_direction(input logic value);
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        // a held escape makes no output, so give the pipe time to settle
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        model_dir      = value;
        model_esc_held = 1'b0;
    endtask

    // receiver stall: a random hold-off after each taken transaction
    always @(posedge i_clk) begin
        recv_stall_nxt = 1'b0;
        if (recv_wait > 0) begin
            recv_wait--;
            recv_stall_nxt = (recv_wait > 0);
        end else if (i_rst_n && o_out_valid && !i_out_stall) begin
            if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
            recv_wait      = draw_wait(recv_calm);
            recv_stall_nxt = (recv_wait > 0);
        end
        i_out_stall <= recv_stall_nxt;
    end

    // compare each output transaction with the oldest expected byte
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected output: out_byte %h run_end %b frame_end %b",
                       o_out_data.out_byte, o_out_data.run_end, o_out_data.frame_end);
                mismatch_count++;
            end else begin
                want = expected_bytes.pop_front();
                if (o_out_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %h, got %h", want.out_byte,
                           o_out_data.out_byte);
                    mismatch_count++;
                end
                if (o_out_data.run_end !== want.run_end) begin
                    $error("run_end: expected %b, got %b", want.run_end,
                           o_out_data.run_end);
                    mismatch_count++;
                end
                if (o_out_data.frame_end !== want.frame_end) begin
                    $error("frame_end: expected %b, got %b", want.frame_end,
                           o_out_data.frame_end);
                    mismatch_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stimulus
    initial begin
        int   sent;
        int   next_switch;
        int   len;
        logic cur_dir;

        // encode after reset: extremes and all four stuffed bytes
        add_row(ROW_BYTE, 8'h00, 1'b0, 1, out_of(8'h00, 1'b1, 1'b0), '0);
        add_row(ROW_BYTE, 8'hFF, 1'b1, 1, out_of(8'hFF, 1'b1, 1'b1), '0);
        add_row(ROW_BYTE, ebsc_pkg::RAW_1A, 1'b0, 2, out_of(ebsc_pkg::ESC_BYTE, 1'b0, 1'b0),
                out_of(ebsc_pkg::CODE_1A, 1'b1, 1'b0));
        add_row(ROW_BYTE, ebsc_pkg::RAW_EF, 1'b0, 2, out_of(ebsc_pkg::ESC_BYTE, 1'b0, 1'b0),
                out_of(ebsc_pkg::CODE_EF, 1'b1, 1'b0));
        add_row(ROW_BYTE, ebsc_pkg::RAW_1B, 1'b1, 2, out_of(ebsc_pkg::ESC_BYTE, 1'b0, 1'b0),
                out_of(ebsc_pkg::CODE_1B, 1'b1, 1'b1));
        add_row(ROW_BYTE, ebsc_pkg::RAW_03, 1'b0, 2, out_of(ebsc_pkg::ESC_BYTE, 1'b0, 1'b0),
                out_of(ebsc_pkg::CODE_03, 1'b1, 1'b0));
        add_row(ROW_BYTE, ebsc_pkg::CODE_1A, 1'b1, 1,
                out_of(ebsc_pkg::CODE_1A, 1'b1, 1'b1), '0);
        // decode: every code pair, a literal escape and frame ends
        add_row(ROW_DIR, {7'd0, ebsc_pkg::DIR_DECODE}, 1'b0, 0, '0, '0);
        add_row(ROW_BYTE, ebsc_pkg::ESC_BYTE, 1'b0, 0, '0, '0);
        add_row(ROW_BYTE, ebsc_pkg::CODE_1A, 1'b0, USE_MODEL, '0, '0);
        add_row(ROW_BYTE, ebsc_pkg::ESC_BYTE, 1'b0, USE_MODEL, '0, '0);
        add_row(ROW_BYTE, ebsc_pkg::CODE_EF, 1'b0, USE_MODEL, '0, '0);
        add_row(ROW_BYTE, ebsc_pkg::ESC_BYTE, 1'b0, USE_MODEL, '0, '0);
        add_row(ROW_BYTE, ebsc_pkg::CODE_1B, 1'b1, USE_MODEL, '0, '0);
        add_row(ROW_BYTE, ebsc_pkg::ESC_BYTE, 1'b0, USE_MODEL, '0, '0);
        add_row(ROW_BYTE, ebsc_pkg::CODE_03, 1'b0, USE_MODEL, '0, '0);
        add_row(ROW_BYTE, ebsc_pkg::ESC_BYTE, 1'b0, USE_MODEL, '0, '0);
        add_row(ROW_BYTE, 8'h55, 1'b0, USE_MODEL, '0, '0);
        add_row(ROW_BYTE, ebsc_pkg::ESC_BYTE, 1'b1, 1,
                out_of(ebsc_pkg::ESC_BYTE, 1'b1, 1'b1), '0);
        add_row(ROW_BYTE, ebsc_pkg::ESC_BYTE, 1'b0, USE_MODEL, '0, '0);
        add_row(ROW_BYTE, 8'h00, 1'b1, USE_MODEL, '0, '0);
        add_row(ROW_BYTE, 8'hFF, 1'b0, 1, out_of(8'hFF, 1'b1, 1'b0), '0);
        // direction write drops a held escape
        add_row(ROW_BYTE, ebsc_pkg::ESC_BYTE, 1'b0, USE_MODEL, '0, '0);
        add_row(ROW_DIR, {7'd0, ebsc_pkg::DIR_DECODE}, 1'b0, 0, '0, '0);
        add_row(ROW_BYTE, ebsc_pkg::CODE_1A, 1'b1, USE_MODEL, '0, '0);
        add_row(ROW_DIR, {7'd0, ebsc_pkg::DIR_ENCODE}, 1'b0, 0, '0, '0);
        add_row(ROW_BYTE, 8'h80, 1'b1, 1, out_of(8'h80, 1'b1, 1'b1), '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_DIR) begin
                write_direction(directed_rows[i].data[0]);
            end else begin
                send_byte(directed_rows[i].data, directed_rows[i].last,
                          directed_rows[i].n_typed == USE_MODEL);
                if (directed_rows[i].n_typed > 0) expected_bytes.push_back(directed_rows[i].r0);
                if (directed_rows[i].n_typed > 1) expected_bytes.push_back(directed_rows[i].r1);
            end
        end

        // random frames, direction changed between frames
        cur_dir     = ebsc_pkg::DIR_ENCODE;
        sent        = 0;
        next_switch = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= next_switch) begin
                if ($urandom_range(0, 3) != 0) cur_dir = ~cur_dir;
                write_direction(cur_dir);
                next_switch = sent + $urandom_range(60, 200);
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            for (int k = 0; k < len; k++) begin
                send_byte(pick_byte(), k == len - 1, 1'b1);
                sent++;
            end
        end

        // drain and finish
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ebsc_pkg.sv
hw/rtl/escape_byte_stuffing_codec.sv
tb/sv/escape_byte_stuffing_codec_test.sv
